/* hw/rtl/bdpc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bdpc_pkg: shared types and constants
// Press event codes, register indexes, reset values and the beat structs
// passed between the debounce press classifier modules.
// ----------------------------------------------------------------------------
package bdpc_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 16;
    localparam int REG_WIDTH           = 16;
    localparam int REG_INDEX_WIDTH     = 2;

    localparam logic [REG_WIDTH-1:0] DEBOUNCE_RESET = 16'd50;
    localparam logic [REG_WIDTH-1:0] LONG_RESET     = 16'd3000;
    localparam logic [REG_WIDTH-1:0] SHORT_RESET    = 16'd500;

    typedef enum logic [REG_INDEX_WIDTH-1:0] {
        REG_DEBOUNCE = 2'd0,
        REG_LONG     = 2'd1,
        REG_SHORT    = 2'd2
    } t_reg_index;

    typedef enum logic [1:0] {
        EVT_NONE  = 2'd0,
        EVT_SHORT = 2'd1,
        EVT_LONG  = 2'd2
    } t_press_event;

    typedef struct packed {
        logic [REG_WIDTH-1:0] debounce_ticks;
        logic [REG_WIDTH-1:0] long_press_ticks;
        logic [REG_WIDTH-1:0] short_press_ticks;
    } t_cfg;

    typedef struct packed {
        t_press_event press_event;
        logic         press_active;
    } t_result;

endpackage
`default_nettype wire

/* hw/rtl/bdpc_cfg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bdpc_cfg: configuration register file
// Holds the debounce, long press and short press thresholds.
// ----------------------------------------------------------------------------
module bdpc_cfg (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [bdpc_pkg::REG_INDEX_WIDTH-1:0]  i_cfg_index,
    input  wire logic [bdpc_pkg::REG_WIDTH-1:0]        i_cfg_wdata,
    output bdpc_pkg::t_cfg                             o_cfg
);

    bdpc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks    <= bdpc_pkg::DEBOUNCE_RESET;
            r_cfg.long_press_ticks  <= bdpc_pkg::LONG_RESET;
            r_cfg.short_press_ticks <= bdpc_pkg::SHORT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bdpc_pkg::REG_DEBOUNCE: r_cfg.debounce_ticks    <= i_cfg_wdata;
                bdpc_pkg::REG_LONG:     r_cfg.long_press_ticks  <= i_cfg_wdata;
                bdpc_pkg::REG_SHORT:    r_cfg.short_press_ticks <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

/* hw/rtl/bdpc_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bdpc_core: input register and per-tick state update
// Registers the sampled level, then updates settle and press counters and
// classifies the press in one pass when the result stage can take the beat.
// ----------------------------------------------------------------------------
module bdpc_core #(
    parameter int COUNT_WIDTH = bdpc_pkg::COUNT_WIDTH_DEFAULT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_button_level,
    input  wire bdpc_pkg::t_cfg i_cfg,
    input  wire logic        i_res_ready,
    output logic             o_res_push,
    output bdpc_pkg::t_result o_res
);

    localparam int CMP_WIDTH = (COUNT_WIDTH > bdpc_pkg::REG_WIDTH) ?
                               COUNT_WIDTH : bdpc_pkg::REG_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic                   r_in_valid;
    logic                   r_in_level;
    logic                   r_prev_level;
    logic [COUNT_WIDTH-1:0] r_settle_count;
    logic                   r_press_held;
    logic [COUNT_WIDTH-1:0] r_press_count;

    logic                   n_prev_level;
    logic [COUNT_WIDTH-1:0] n_settle_count;
    logic                   n_press_held;
    logic [COUNT_WIDTH-1:0] n_press_count;
    bdpc_pkg::t_press_event n_event;

    logic                   push;
    logic                   trusted;
    logic [CMP_WIDTH-1:0]   settle_ext;
    logic [CMP_WIDTH-1:0]   press_ext;
    logic [CMP_WIDTH-1:0]   debounce_ext;
    logic [CMP_WIDTH-1:0]   long_ext;
    logic [CMP_WIDTH-1:0]   short_ext;

    assign push    = r_in_valid && i_res_ready;
    assign o_stall = r_in_valid && !i_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_level <= i_button_level;
        end
    end

    always_comb begin
        debounce_ext = CMP_WIDTH'(i_cfg.debounce_ticks);
        long_ext     = CMP_WIDTH'(i_cfg.long_press_ticks);
        short_ext    = CMP_WIDTH'(i_cfg.short_press_ticks);

        n_press_count = r_press_count;
        if (r_press_held && r_press_count != COUNT_MAX) begin
            n_press_count = r_press_count + COUNT_WIDTH'(1);
        end

        if (r_in_level != r_prev_level) begin
            n_settle_count = '0;
        end else if (r_settle_count != COUNT_MAX) begin
            n_settle_count = r_settle_count + COUNT_WIDTH'(1);
        end else begin
            n_settle_count = r_settle_count;
        end

        settle_ext = CMP_WIDTH'(n_settle_count);
        press_ext  = CMP_WIDTH'(n_press_count);
        trusted    = settle_ext > debounce_ext;

        n_press_held = r_press_held;
        n_event      = bdpc_pkg::EVT_NONE;
        if (trusted) begin
            if (!r_in_level && !r_press_held) begin
                n_press_held  = 1'b1;
                n_press_count = '0;
            end else if (r_in_level && r_press_held) begin
                if (press_ext >= long_ext) begin
                    n_event = bdpc_pkg::EVT_LONG;
                end else if (press_ext >= short_ext) begin
                    n_event = bdpc_pkg::EVT_SHORT;
                end
                n_press_held = 1'b0;
            end
        end

        n_prev_level = r_in_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level   <= 1'b1;
            r_settle_count <= '0;
            r_press_held   <= 1'b0;
            r_press_count  <= '0;
        end else if (push) begin
            r_prev_level   <= n_prev_level;
            r_settle_count <= n_settle_count;
            r_press_held   <= n_press_held;
            r_press_count  <= n_press_count;
        end
    end

    assign o_res_push            = push;
    assign o_res.press_event     = n_event;
    assign o_res.press_active    = n_press_held;

    a_end_clears_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && n_event != bdpc_pkg::EVT_NONE) |=> !r_press_held)
        else $error("press event without ending the press");

    a_start_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !r_press_held && n_press_held) |=> (r_press_count == '0))
        else $error("press count not cleared at press start");

    a_change_clears_settle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && r_in_level != r_prev_level) |=> (r_settle_count == '0))
        else $error("settle count not cleared on level change");

    a_stall_holds_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> (r_in_valid && $stable(r_in_level)))
        else $error("held input beat lost");

endmodule
`default_nettype wire

/* hw/rtl/bdpc_out.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bdpc_out: result register
// Holds one result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module bdpc_out (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire bdpc_pkg::t_result i_res,
    output logic              o_ready,
    output logic              o_valid,
    input  wire logic         i_stall,
    output logic [1:0]        o_press_event,
    output logic              o_press_active
);

    logic              r_valid;
    bdpc_pkg::t_result r_res;

    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_push) begin
            r_res <= i_res;
        end
    end

    assign o_valid        = r_valid;
    assign o_press_event  = r_res.press_event;
    assign o_press_active = r_res.press_active;

endmodule
`default_nettype wire

/* hw/rtl/button_debounce_press_classifier_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// button_debounce_press_classifier_top: debounced short/long press detector
// Takes one raw active-low button sample per beat and returns one result beat
// per sample with the press event and whether a debounced press is active.
// ----------------------------------------------------------------------------
// One sample is accepted every clock cycle while the input is not stalled. A
// sample is captured in the input register and processed, and its result is
// captured in the result register, from which the downstream side takes it.
// A stall on the result side holds the result register and, while it is
// full, stalls the input. The settle and press counters are updated in a
// single pass between these two registers, and the counters saturate at
// 2^COUNT_WIDTH-1. Thresholds are to be written through the configuration
// port only while no beat is in flight; the user, not the block, enforces it.
module button_debounce_press_classifier_top #(
    parameter int COUNT_WIDTH = bdpc_pkg::COUNT_WIDTH_DEFAULT
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [bdpc_pkg::REG_INDEX_WIDTH-1:0] i_cfg_index,
    input  wire logic [bdpc_pkg::REG_WIDTH-1:0]       i_cfg_wdata,
    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire logic                                 i_button_level,
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output logic [1:0]                                o_press_event,
    output logic                                      o_press_active
);

    bdpc_pkg::t_cfg    cfg;
    bdpc_pkg::t_result res;
    logic              res_push;
    logic              res_ready;

    bdpc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    bdpc_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_button_level (i_button_level),
        .i_cfg          (cfg),
        .i_res_ready    (res_ready),
        .o_res_push     (res_push),
        .o_res          (res)
    );

    bdpc_out u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (res_push),
        .i_res          (res),
        .o_ready        (res_ready),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_press_event  (o_press_event),
        .o_press_active (o_press_active)
    );

endmodule
`default_nettype wire
